>>> src/pidl_pkg.sv
// Shared definitions for the positional insert/delete list.
// Operation and status codes, controller/datapath command and status types.
package pidl_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_SEARCH = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic load;
      logic decode;
      logic step;
      logic commit;
      logic emit;
   } pidl_cmd_type;

   typedef struct packed {
      logic done;
   } pidl_stat_type;

endpackage

>>> src/positional_insert_delete_list_top.sv
// Positional insert/delete list: ordered store of signed 32-bit values.
// Each request passes decode, a move step, commit and output. The move step shifts entries
// (insert: count - position, delete: count - position - 1) or reads them (search, up to the
// first match), and moves none on errors. The next request is taken only after the result
// issues, the entry RAM moving one entry per cycle. Sync reset empties the list; stored
// values are kept. Depends on pidl_pkg, pidl_ctrl, pidl_datapath.
module positional_insert_delete_list_top #(
   parameter int CAPACITY = pidl_pkg::CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_found_position,
   output logic [6:0]         rsp_count_after
);

   pidl_pkg::pidl_cmd_type  cmd;
   pidl_pkg::pidl_stat_type stat;

   pidl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pidl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_count_after    (rsp_count_after)
   );

endmodule

>>> src/pidl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pidl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/pidl_ctrl.sv
// Sequencing state machine for the positional insert/delete list.
// Depends on pidl_pkg for the command and status types.
module pidl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  pidl_pkg::pidl_stat_type stat,
   output pidl_pkg::pidl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_MOVE   = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_MOVE;
         end
         S_MOVE: begin
            cmd.step = 1'b1;
            if (stat.done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/pidl_datapath.sv
// Datapath of the positional insert/delete list: entry RAM, count, shift
// and scan pointers, result registers. Depends on pidl_pkg and pidl_ram.
module pidl_datapath #(
   parameter int CAPACITY = pidl_pkg::CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pidl_pkg::pidl_cmd_type  cmd,
   output pidl_pkg::pidl_stat_type stat,
   input  logic [1:0]              req_mode,
   input  logic [6:0]              req_position,
   input  logic signed [31:0]      req_value,
   output logic [1:0]              rsp_status,
   output logic [5:0]              rsp_found_position,
   output logic [6:0]              rsp_count_after
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;
   localparam int FW   = (AW > 6) ? AW : 6;

   logic [1:0]    mode_ff;
   logic [6:0]    pos_ff;
   logic [31:0]   val_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] last_ff, last_in;
   logic [CW-1:0] left_ff, left_in;
   logic          pend_ff, pend_in;
   logic          hit_ff, hit_in;
   logic          ins_ff, ins_in;
   logic          del_ff, del_in;
   logic          srch_ff, srch_in;
   logic          up_ff, up_in;
   logic [1:0]    status_ff, status_in;
   logic [AW-1:0] found_ff, found_in;
   logic [1:0]    rsp_status_ff;
   logic [5:0]    rsp_found_ff;
   logic [6:0]    rsp_count_ff;

   logic [CMPW-1:0] pos_x, cnt_x, cnt_out_x;
   logic [CW-1:0]   pos_c, pos_inc;
   logic [FW-1:0]   found_x;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [31:0]     wr_data;
   logic [31:0]     rd_data;

   assign pos_x   = CMPW'(pos_ff);
   assign cnt_x   = CMPW'(count_ff);
   assign pos_c   = pos_x[CW-1:0];
   assign pos_inc = pos_c + CW'(1);

   always_comb begin
      ptr_in    = ptr_ff;
      last_in   = last_ff;
      left_in   = left_ff;
      pend_in   = pend_ff;
      hit_in    = hit_ff;
      ins_in    = ins_ff;
      del_in    = del_ff;
      srch_in   = srch_ff;
      up_in     = up_ff;
      status_in = status_ff;
      found_in  = found_ff;
      count_in  = count_ff;

      if (cmd.decode) begin
         pend_in   = 1'b0;
         hit_in    = 1'b0;
         ins_in    = 1'b0;
         del_in    = 1'b0;
         srch_in   = 1'b0;
         up_in     = 1'b1;
         left_in   = '0;
         ptr_in    = '0;
         found_in  = '0;
         status_in = pidl_pkg::ST_OK;
         unique case (mode_ff)
            pidl_pkg::MODE_INSERT: begin
               if (pos_x > cnt_x) begin
                  status_in = pidl_pkg::ST_RANGE;
               end else if (count_ff == CW'(CAPACITY)) begin
                  status_in = pidl_pkg::ST_FULL;
               end else begin
                  ins_in  = 1'b1;
                  up_in   = 1'b0;
                  left_in = count_ff - pos_c;
                  ptr_in  = AW'(count_ff - CW'(1));
               end
            end
            pidl_pkg::MODE_DELETE: begin
               if (pos_x >= cnt_x) begin
                  status_in = pidl_pkg::ST_RANGE;
               end else begin
                  del_in  = 1'b1;
                  left_in = count_ff - pos_inc;
                  ptr_in  = AW'(pos_inc);
               end
            end
            pidl_pkg::MODE_SEARCH: begin
               srch_in   = 1'b1;
               left_in   = count_ff;
               status_in = pidl_pkg::ST_NOTFOUND;
            end
            default: begin
               status_in = pidl_pkg::ST_OK;
            end
         endcase
      end

      if (cmd.step) begin
         if (left_ff != '0) begin
            ptr_in  = up_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
            left_in = left_ff - CW'(1);
            pend_in = 1'b1;
            last_in = ptr_ff;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff && srch_ff && !hit_ff && (rd_data == val_ff)) begin
            hit_in    = 1'b1;
            status_in = pidl_pkg::ST_OK;
            found_in  = last_ff;
         end
      end

      if (cmd.commit) begin
         if (ins_ff) begin
            count_in = count_ff + CW'(1);
         end else if (del_ff) begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   assign stat.done = hit_ff || (!pend_ff && (left_ff == '0));

   assign wr_en   = (cmd.step && pend_ff && (ins_ff || del_ff)) || (cmd.commit && ins_ff);
   assign wr_addr = cmd.commit ? AW'(pos_c) : (ins_ff ? last_ff + AW'(1) : last_ff - AW'(1));
   assign wr_data = cmd.commit ? val_ff : rd_data;

   pidl_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         pos_ff  <= req_position;
         val_ff  <= req_value;
      end
      ptr_ff    <= ptr_in;
      last_ff   <= last_in;
      left_ff   <= left_in;
      pend_ff   <= pend_in;
      hit_ff    <= hit_in;
      ins_ff    <= ins_in;
      del_ff    <= del_in;
      srch_ff   <= srch_in;
      up_ff     <= up_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   assign found_x   = FW'(found_ff);
   assign cnt_out_x = CMPW'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_x[5:0];
         rsp_count_ff  <= cnt_out_x[6:0];
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_count_after    = rsp_count_ff;

endmodule

>>> bench/list_op_checker.sv
// Watches both channels of the positional insert/delete list, keeps a shadow copy of
// the list, and compares every reply beat with the oldest predicted reply.
// Depends on pidl_pkg for the operation and status codes.
module list_op_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic [5:0]         rsp_found_position,
   input  logic [6:0]         rsp_count_after,
   output int                 fail_count,
   output int                 outstanding
);

   localparam int LIST_DEPTH = pidl_pkg::CAPACITY_DEF;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] found_position;
      logic [6:0] count_after;
   } list_reply_type;

   logic signed [31:0] shadow_list[$];
   list_reply_type     expected_replies[$];
   list_reply_type     due;

   function automatic list_reply_type apply_list_op(input logic [1:0] op,
                                                    input logic [6:0] pos,
                                                    input logic signed [31:0] val);
      list_reply_type r;
      int             idx;
      bit             hit;
      r = '0;
      hit = 1'b0;
      case (op)
         pidl_pkg::MODE_INSERT: begin
            if (pos > shadow_list.size())
               r.status = pidl_pkg::ST_RANGE;
            else if (shadow_list.size() >= LIST_DEPTH)
               r.status = pidl_pkg::ST_FULL;
            else
               shadow_list.insert(pos, val);
         end
         pidl_pkg::MODE_DELETE: begin
            if (pos >= shadow_list.size())
               r.status = pidl_pkg::ST_RANGE;
            else
               shadow_list.delete(pos);
         end
         pidl_pkg::MODE_SEARCH: begin
            r.status = pidl_pkg::ST_NOTFOUND;
            for (idx = 0; idx < shadow_list.size() && !hit; idx++) begin
               if (shadow_list[idx] == val) begin
                  hit = 1'b1;
                  r.status = pidl_pkg::ST_OK;
                  r.found_position = idx[5:0];
               end
            end
         end
         default: ;
      endcase
      r.count_after = 7'(shadow_list.size());
      return r;
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_list.delete();
         expected_replies.delete();
         outstanding <= 0;
      end else begin
         if (req_valid === 1'b1 && req_stall === 1'b0)
            expected_replies.push_back(apply_list_op(req_mode, req_position, req_value));
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_replies.size() == 0) begin
               $error("reply beat with no request outstanding");
               fail_count++;
            end else begin
               due = expected_replies.pop_front();
               compare_field("status", due.status, rsp_status);
               compare_field("found_position", due.found_position, rsp_found_position);
               compare_field("count_after", due.count_after, rsp_count_after);
            end
         end
         outstanding <= expected_replies.size();
      end
   end

endmodule

>>> bench/tb_positional_insert_delete_list_top.sv
// Testbench top for the positional insert/delete list: drives clock, reset, request
// beats and reply back-pressure, and gives the verdict from list_op_checker.
// Depends on pidl_pkg, list_op_checker and positional_insert_delete_list_top.
module tb_positional_insert_delete_list_top;

   localparam int          LIST_DEPTH   = pidl_pkg::CAPACITY_DEF;
   localparam int          RANDOM_ITEMS = 1680;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam logic [1:0]  MODE_UNUSED  = 2'd3;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_mode;
   logic [6:0]         req_position;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [5:0]         rsp_found_position;
   logic [6:0]         rsp_count_after;
   int                 fail_count;
   int                 outstanding;
   int                 tracked_len;
   bit                 sender_steady;

   positional_insert_delete_list_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_count_after    (rsp_count_after)
   );

   list_op_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_count_after    (rsp_count_after),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] draw_entry_value();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = 32'($urandom_range(0, 7)) - 32'd4;
         4:          v = 32'h8000_0000;
         5:          v = 32'h7FFF_FFFF;
         default:    v = $urandom;
      endcase
      return v;
   endfunction

   task automatic offer_list_op(input logic [1:0] op, input logic [6:0] pos,
                                input logic [31:0] val);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= op;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      case (op)
         pidl_pkg::MODE_INSERT: if (pos <= tracked_len && tracked_len < LIST_DEPTH) tracked_len++;
         pidl_pkg::MODE_DELETE: if (pos < tracked_len) tracked_len--;
         default: ;
      endcase
   endtask

   initial begin : request_source
      int          n;
      int          pick;
      bit          growing;
      logic [1:0]  op;
      logic [6:0]  pos;
      logic [31:0] val;
      growing       = 1'b0;
      sender_steady = 1'b0;
      tracked_len   = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_mode     <= pidl_pkg::MODE_INSERT;
      req_position <= '0;
      req_value    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      offer_list_op(pidl_pkg::MODE_DELETE, 7'd0,   32'h1234_5678);
      offer_list_op(pidl_pkg::MODE_SEARCH, 7'd0,   32'h0000_0000);
      offer_list_op(pidl_pkg::MODE_INSERT, 7'd1,   32'h0000_0001);
      offer_list_op(MODE_UNUSED,           7'd127, 32'hFFFF_FFFF);
      offer_list_op(pidl_pkg::MODE_INSERT, 7'd0,   32'h7FFF_FFFF);
      offer_list_op(pidl_pkg::MODE_INSERT, 7'd0,   32'h8000_0000);
      offer_list_op(pidl_pkg::MODE_INSERT, 7'd2,   32'hFFFF_FFFF);
      offer_list_op(pidl_pkg::MODE_INSERT, 7'd1,   32'h0000_0005);
      offer_list_op(pidl_pkg::MODE_INSERT, 7'd4,   32'h0000_0005);
      offer_list_op(pidl_pkg::MODE_SEARCH, 7'd127, 32'h0000_0005);
      offer_list_op(pidl_pkg::MODE_SEARCH, 7'd0,   32'hFFFF_FFFF);
      offer_list_op(pidl_pkg::MODE_SEARCH, 7'd0,   32'h8000_0000);
      offer_list_op(pidl_pkg::MODE_SEARCH, 7'd0,   32'h0000_0007);
      offer_list_op(pidl_pkg::MODE_INSERT, 7'd6,   32'h0000_0001);
      offer_list_op(pidl_pkg::MODE_DELETE, 7'd5,   32'h0000_0000);
      offer_list_op(pidl_pkg::MODE_DELETE, 7'd4,   32'hFFFF_FFFF);
      offer_list_op(pidl_pkg::MODE_SEARCH, 7'd0,   32'h0000_0005);
      offer_list_op(pidl_pkg::MODE_DELETE, 7'd0,   32'h0000_0000);
      offer_list_op(pidl_pkg::MODE_SEARCH, 7'd0,   32'h8000_0000);
      offer_list_op(pidl_pkg::MODE_DELETE, 7'd127, 32'h0000_0000);
      offer_list_op(pidl_pkg::MODE_INSERT, 7'd127, 32'h0000_0000);
      offer_list_op(MODE_UNUSED,           7'd0,   32'h0000_0000);
      offer_list_op(pidl_pkg::MODE_SEARCH, 7'd64,  32'hFFFF_FFFF);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) growing = !growing;
         if (n % 50 == 0) sender_steady = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < (growing ? 70 : 8))
            op = pidl_pkg::MODE_INSERT;
         else if (pick < 78)
            op = pidl_pkg::MODE_DELETE;
         else if (pick < 95)
            op = pidl_pkg::MODE_SEARCH;
         else
            op = MODE_UNUSED;
         pos = 7'($urandom_range(0, 127));
         val = draw_entry_value();
         if ($urandom_range(0, 99) >= 12) begin
            if (op == pidl_pkg::MODE_INSERT)
               pos = 7'($urandom_range(0, tracked_len));
            else if (op == pidl_pkg::MODE_DELETE && tracked_len > 0)
               pos = 7'($urandom_range(0, tracked_len - 1));
         end
         if (op == pidl_pkg::MODE_DELETE) val = $urandom;
         offer_list_op(op, pos, val);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (fail_count == 0)
         $display("PASS positional_insert_delete_list_top");
      else
         $display("FAIL positional_insert_delete_list_top");
      $finish;
   end

   initial begin : reply_sink
      int hold;
      int beats;
      bit steady;
      beats  = 0;
      steady = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (beats % 50 == 0) steady = ($urandom_range(0, 3) == 0);
         hold = steady ? 0 : $urandom_range(0, 17);
         // hold off long enough for the list to back up onto the request side
         if (beats == 250) hold = 600;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         beats++;
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL positional_insert_delete_list_top");
      $finish;
   end

endmodule

>>> sim.f
src/pidl_pkg.sv
src/pidl_ram.sv
src/pidl_ctrl.sv
src/pidl_datapath.sv
src/positional_insert_delete_list_top.sv
bench/list_op_checker.sv
bench/tb_positional_insert_delete_list_top.sv
